// ===== hw/rtl/sorted_insert_priority_queue_macros.svh =====
// Assertion macros used by the back end of the sorted insert priority queue RTL.
`ifndef SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define SIQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted insert priority queue: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define SIQ_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted insert priority queue: next-cycle check failed");

`endif

// ===== hw/rtl/siq_pkg.sv =====
// Shared types and codes of the sorted insert priority queue.
`default_nettype none

package siq_pkg;

	localparam int FUNC_BITS = 2;
	localparam int POS_BITS  = 4;
	localparam int OCC_BITS  = 5;

	typedef logic [FUNC_BITS-1:0] func_t;
	typedef logic [1:0]           status_t;
	typedef logic [POS_BITS-1:0]  pos_t;
	typedef logic [OCC_BITS-1:0]  occ_t;

	localparam func_t FUNC_INSERT = 2'd0;
	localparam func_t FUNC_REMOVE = 2'd1;
	localparam func_t FUNC_LIST   = 2'd2;
	localparam func_t FUNC_CLEAR  = 2'd3;

	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_EMPTY = 2'd1;
	localparam status_t STATUS_FULL  = 2'd2;

	// Decoded command, one bit per operation.
	typedef struct packed {
		logic ins;
		logic rem;
		logic lst;
		logic clr;
	} op_t;

	// Everything in a result besides the entry key and tag.
	typedef struct packed {
		status_t status;
		pos_t    pos;
		occ_t    occ;
		logic    last;
	} res_info_t;

endpackage

`default_nettype wire

// ===== hw/rtl/siq_front.sv =====
// Front end: accepts commands, decodes them and holds them in a two-entry queue.
`default_nettype none

module siq_front #(
	parameter int KEY_BITS = 40,
	parameter int TAG_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire siq_pkg::func_t       func,
	input  wire logic [KEY_BITS-1:0]  key,
	input  wire logic [TAG_BITS-1:0]  tag,
	output logic                      cmd_valid,
	input  wire logic                 cmd_ready,
	output siq_pkg::op_t              cmd_op,
	output logic [KEY_BITS-1:0]       cmd_key,
	output logic [TAG_BITS-1:0]       cmd_tag
);

	siq_pkg::op_t        op_mem [2];
	logic [KEY_BITS-1:0] key_mem [2];
	logic [TAG_BITS-1:0] tag_mem [2];

	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       wr_en;
	logic       rd_en;
	siq_pkg::op_t in_op;

	always_comb begin
		in_op = '0;
		case (func)
			siq_pkg::FUNC_INSERT: in_op.ins = 1'b1;
			siq_pkg::FUNC_REMOVE: in_op.rem = 1'b1;
			siq_pkg::FUNC_LIST:   in_op.lst = 1'b1;
			siq_pkg::FUNC_CLEAR:  in_op.clr = 1'b1;
			default:              in_op.clr = 1'b1;
		endcase
	end

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign wr_en     = push && !full;
	assign rd_en     = cmd_valid && cmd_ready;

	assign cmd_op  = op_mem[rd_ptr_q];
	assign cmd_key = key_mem[rd_ptr_q];
	assign cmd_tag = tag_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			op_mem[wr_ptr_q]  <= in_op;
			key_mem[wr_ptr_q] <= key;
			tag_mem[wr_ptr_q] <= tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/siq_back.sv =====
// Back end: the sorted cell row and the command sequencer that drives it.
`default_nettype none
`include "sorted_insert_priority_queue_macros.svh"

module siq_back #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 40,
	parameter int TAG_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	output logic                      cmd_ready,
	input  wire siq_pkg::op_t         cmd_op,
	input  wire logic [KEY_BITS-1:0]  cmd_key,
	input  wire logic [TAG_BITS-1:0]  cmd_tag,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output siq_pkg::res_info_t        res_info,
	output logic [KEY_BITS-1:0]       res_key,
	output logic [TAG_BITS-1:0]       res_tag
);

	localparam int FILL_W = $clog2(CAPACITY + 1);
	localparam int IDX_W  = $clog2(CAPACITY);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_LIST = 1'b1;

	logic [KEY_BITS-1:0] key_q [CAPACITY];
	logic [TAG_BITS-1:0] tag_q [CAPACITY];
	logic [KEY_BITS-1:0] key_d [CAPACITY];
	logic [TAG_BITS-1:0] tag_d [CAPACITY];

	// Neighbor values seen by each cell.
	logic [KEY_BITS-1:0] shl_key [CAPACITY];
	logic [TAG_BITS-1:0] shl_tag [CAPACITY];
	logic [KEY_BITS-1:0] shr_key [CAPACITY];
	logic [TAG_BITS-1:0] shr_tag [CAPACITY];
	logic [CAPACITY-1:0] le;
	logic [CAPACITY-1:0] ins_here;

	logic              state_q;
	logic              state_d;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_d;
	logic [FILL_W-1:0] fill_m1;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  idx_d;
	logic              is_full;
	logic              is_empty;
	logic              list_end;
	logic              fire;

	assign fill_m1  = fill_q - FILL_W'(1);
	assign is_full  = (fill_q == FILL_W'(CAPACITY));
	assign is_empty = (fill_q == '0);
	assign list_end = (FILL_W'(idx_q) == fill_m1);

	// Each cell compares its key with the new key; the row of results marks
	// the insertion point as the first cell that is unused or whose key is larger.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign le[i] = (FILL_W'(i) < fill_q) && (key_q[i] <= cmd_key);
		if (i == 0) begin : g_first
			assign ins_here[i] = 1'b1;
			assign shr_key[i]  = cmd_key;
			assign shr_tag[i]  = cmd_tag;
		end else begin : g_rest
			assign ins_here[i] = le[i-1];
			assign shr_key[i]  = key_q[i-1];
			assign shr_tag[i]  = tag_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign shl_key[i] = key_q[0];
			assign shl_tag[i] = tag_q[0];
		end else begin : g_body
			assign shl_key[i] = key_q[i+1];
			assign shl_tag[i] = tag_q[i+1];
		end
	end

	assign res_valid = (state_q == ST_LIST) || cmd_valid;
	assign cmd_ready = (state_q == ST_IDLE) && res_ready;
	assign fire      = res_valid && res_ready;

	always_comb begin
		key_d   = key_q;
		tag_d   = tag_q;
		fill_d  = fill_q;
		state_d = state_q;
		idx_d   = idx_q;
		res_key = '0;
		res_tag = '0;
		res_info.status = siq_pkg::STATUS_OK;
		res_info.pos    = '0;
		res_info.last   = 1'b1;

		if (state_q == ST_LIST) begin
			res_key       = key_q[0];
			res_tag       = tag_q[0];
			res_info.pos  = siq_pkg::pos_t'(idx_q);
			res_info.last = list_end;
			if (res_ready) begin
				// Rotate the valid part of the row so the next entry reaches cell zero.
				for (int i = 0; i < CAPACITY; i++) begin
					key_d[i] = (FILL_W'(i) == fill_m1) ? key_q[0] : shl_key[i];
					tag_d[i] = (FILL_W'(i) == fill_m1) ? tag_q[0] : shl_tag[i];
				end
				idx_d = idx_q + IDX_W'(1);
				if (list_end) begin
					state_d = ST_IDLE;
				end
			end
		end else if (cmd_op.ins) begin
			if (is_full) begin
				res_info.status = siq_pkg::STATUS_FULL;
			end else if (fire) begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (!le[i]) begin
						key_d[i] = ins_here[i] ? cmd_key : shr_key[i];
						tag_d[i] = ins_here[i] ? cmd_tag : shr_tag[i];
					end
				end
				fill_d = fill_q + FILL_W'(1);
			end
		end else if (cmd_op.rem) begin
			if (is_empty) begin
				res_info.status = siq_pkg::STATUS_EMPTY;
			end else begin
				res_key = key_q[0];
				res_tag = tag_q[0];
				if (fire) begin
					key_d  = shl_key;
					tag_d  = shl_tag;
					fill_d = fill_m1;
				end
			end
		end else if (cmd_op.lst) begin
			if (is_empty) begin
				res_info.status = siq_pkg::STATUS_EMPTY;
			end else begin
				res_key       = key_q[0];
				res_tag       = tag_q[0];
				res_info.last = (fill_q == FILL_W'(1));
				if (fire) begin
					for (int i = 0; i < CAPACITY; i++) begin
						key_d[i] = (FILL_W'(i) == fill_m1) ? key_q[0] : shl_key[i];
						tag_d[i] = (FILL_W'(i) == fill_m1) ? tag_q[0] : shl_tag[i];
					end
					idx_d = IDX_W'(1);
					if (fill_q != FILL_W'(1)) begin
						state_d = ST_LIST;
					end
				end
			end
		end else if (cmd_op.clr) begin
			if (fire) begin
				fill_d = '0;
			end
		end

		res_info.occ = siq_pkg::occ_t'(fill_d);
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
		tag_q <= tag_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			idx_q   <= idx_d;
		end
	end

	`SIQ_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= FILL_W'(CAPACITY))
	`SIQ_ASSERT_IMP(a_list_nonempty, state_q == ST_LIST, fill_q != '0)
	`SIQ_ASSERT_IMP(a_list_index, state_q == ST_LIST, FILL_W'(idx_q) < fill_q)
	`SIQ_ASSERT_NXT(a_list_fill_holds, state_q == ST_LIST, fill_q == $past(fill_q))
	`SIQ_ASSERT_IMP(a_no_cmd_while_list, state_q == ST_LIST, !cmd_ready)

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_insert_priority_queue.sv =====
// Top level of the sorted insert priority queue: front end, cell row and result register.
// Path: a command waits in the front queue, the cell row works on the head of that queue
// and the result register captures the result that the cell row gives for it.
// Each insert, remove and clear gives one result; a list gives one result per stored entry
// (one EMPTY result when empty); the cell row runs one command at a time.
// Reset: arst_n low empties the command queue and the result register and sets the count to zero.
`default_nettype none

module sorted_insert_priority_queue #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 40,
	parameter int TAG_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire siq_pkg::func_t       func,
	input  wire logic [KEY_BITS-1:0]  key,
	input  wire logic [TAG_BITS-1:0]  tag,
	output logic                      empty,
	input  wire logic                 pop,
	output siq_pkg::status_t          status,
	output logic [KEY_BITS-1:0]       entry_key,
	output logic [TAG_BITS-1:0]       entry_tag,
	output siq_pkg::pos_t             position,
	output siq_pkg::occ_t             occupancy,
	output logic                      last
);

	// Decoded commands waiting for the cell row.
	logic                cmd_valid;
	logic                cmd_ready;
	siq_pkg::op_t        cmd_op;
	logic [KEY_BITS-1:0] cmd_key;
	logic [TAG_BITS-1:0] cmd_tag;

	// Results leaving the cell row.
	logic                res_valid;
	logic                res_ready;
	siq_pkg::res_info_t  res_info;
	logic [KEY_BITS-1:0] res_key;
	logic [TAG_BITS-1:0] res_tag;

	// Result register seen on the output ports.
	logic                out_valid_q;
	siq_pkg::res_info_t  out_info_q;
	logic [KEY_BITS-1:0] out_key_q;
	logic [TAG_BITS-1:0] out_tag_q;

	siq_front #(
		.KEY_BITS (KEY_BITS),
		.TAG_BITS (TAG_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.func      (func),
		.key       (key),
		.tag       (tag),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_op    (cmd_op),
		.cmd_key   (cmd_key),
		.cmd_tag   (cmd_tag)
	);

	siq_back #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS),
		.TAG_BITS (TAG_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_op    (cmd_op),
		.cmd_key   (cmd_key),
		.cmd_tag   (cmd_tag),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_info  (res_info),
		.res_key   (res_key),
		.res_tag   (res_tag)
	);

	// The result register refills in the same cycle that its old contents are
	// popped, so a waiting result holds up the cell row and the front queue
	// only while the consumer does not pop.
	assign res_ready = !out_valid_q || pop;

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_info_q <= res_info;
			out_key_q  <= res_key;
			out_tag_q  <= res_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	assign empty     = !out_valid_q;
	assign status    = out_info_q.status;
	assign entry_key = out_key_q;
	assign entry_tag = out_tag_q;
	assign position  = out_info_q.pos;
	assign occupancy = out_info_q.occ;
	assign last      = out_info_q.last;

endmodule

`default_nettype wire
